// ===== hdl/vda_pkg.sv =====
// vda_pkg: constants, types and the arctangent table for vector_direction_angle
// no dependencies
package vda_pkg;

  localparam int COMPONENT_WIDTH     = 16;
  localparam int ANGLE_FRACTION_BITS = 6;

  localparam int ZFRAC       = 20;
  localparam int GUARD       = 24;
  localparam int ITERS       = 24;
  localparam int ANGLE_WIDTH = 9 + ANGLE_FRACTION_BITS;
  localparam int MAG_W       = COMPONENT_WIDTH + 1;
  localparam int XW          = COMPONENT_WIDTH + GUARD + 3;
  localparam int TW          = 27;
  localparam int ZW          = TW + 1;
  localparam int AW          = 29;
  localparam int ROUND_SHIFT = ZFRAC - ANGLE_FRACTION_BITS;

  localparam logic [TW-1:0] DEG45  = TW'(45) << ZFRAC;
  localparam logic [TW-1:0] DEG90  = TW'(90) << ZFRAC;
  localparam logic [AW-1:0] DEG180 = AW'(180) << ZFRAC;
  localparam logic [AW-1:0] DEG360 = AW'(360) << ZFRAC;
  localparam logic [AW:0]   ROUND_HALF = (AW + 1)'(1) << (ROUND_SHIFT - 1);
  localparam logic [ANGLE_WIDTH-1:0] FULL_TURN = ANGLE_WIDTH'(360) << ANGLE_FRACTION_BITS;

  typedef enum logic [2:0] {
    KIND_ZERO_DEG,
    KIND_RIGHT,
    KIND_DIAG,
    KIND_OCT,
    KIND_OCT_SWAP
  } angle_kind_e;

  typedef struct packed {
    logic        zero;
    angle_kind_e kind;
    logic        u_neg;
    logic        v_neg;
  } info_t;

  // atan(2^-i) in units of 2^-20 degree
  function automatic logic [ZW-1:0] atan_lut(input int unsigned i);
    logic [ZW-1:0] r;
    unique case (i)
      0:  r = ZW'(47185920);
      1:  r = ZW'(27855475);
      2:  r = ZW'(14718068);
      3:  r = ZW'(7471121);
      4:  r = ZW'(3750058);
      5:  r = ZW'(1876857);
      6:  r = ZW'(938658);
      7:  r = ZW'(469357);
      8:  r = ZW'(234682);
      9:  r = ZW'(117342);
      10: r = ZW'(58671);
      11: r = ZW'(29335);
      12: r = ZW'(14668);
      13: r = ZW'(7334);
      14: r = ZW'(3667);
      15: r = ZW'(1833);
      16: r = ZW'(917);
      17: r = ZW'(458);
      18: r = ZW'(229);
      19: r = ZW'(115);
      20: r = ZW'(57);
      21: r = ZW'(29);
      22: r = ZW'(14);
      23: r = ZW'(7);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/vector_direction_angle.sv =====
// vector_direction_angle: pipelined four-quadrant arctangent of a screen-space vector
// depends on vda_pkg (constants, info_t, atan_lut)

// Takes one vector per cycle and returns its direction, counter-clockwise from +x with
// y pointing down on screen, in 1/64 degree. On its way to valid_o each beat is taken into the
// input register, then passes one fold stage, 24 CORDIC stages of one iteration each, two angle
// rebuild stages and the output register. The rate
// of one beat per cycle is set by that stage line, which always advances unless the
// two-entry output buffer is full; ready_o is low only while both output entries hold beats.
// Axis, diagonal and zero vectors give exact angles; a zero vector gives angle 0 with
// zero_vector_o set.
module vector_direction_angle
  import vda_pkg::*;
(
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [COMPONENT_WIDTH-1:0] velocity_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] velocity_y_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic        [ANGLE_WIDTH-1:0]     angle_o,
  output logic                              zero_vector_o
);

  logic en;
  logic skid_vld_q, skid_vld_d;
  logic out_vld_q, out_vld_d;

  assign ready_o = !skid_vld_q;
  assign en      = !skid_vld_q;

  // input stage
  logic                              s0_vld_q;
  logic signed [COMPONENT_WIDTH-1:0] vx_q, vy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vx_q <= velocity_x_i;
      vy_q <= velocity_y_i;
    end
  end

  // fold into the first octant
  logic signed [MAG_W-1:0] u, v;
  logic        [MAG_W-1:0] au, av, p, q;
  info_t                   fold_info;

  always_comb begin
    u = {vx_q[COMPONENT_WIDTH-1], vx_q};
    v = -{vy_q[COMPONENT_WIDTH-1], vy_q};
    au = u[MAG_W-1] ? MAG_W'(-u) : MAG_W'(u);
    av = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
    fold_info.zero  = (au == '0) && (av == '0);
    fold_info.u_neg = u[MAG_W-1];
    fold_info.v_neg = v[MAG_W-1];
    priority if (av == '0) begin
      fold_info.kind = KIND_ZERO_DEG;
    end else if (au == '0) begin
      fold_info.kind = KIND_RIGHT;
    end else if (au == av) begin
      fold_info.kind = KIND_DIAG;
    end else if (av < au) begin
      fold_info.kind = KIND_OCT;
    end else begin
      fold_info.kind = KIND_OCT_SWAP;
    end
    if (av < au) begin
      p = au;
      q = av;
    end else begin
      p = av;
      q = au;
    end
  end

  // cordic stage line
  logic                 c_vld_q  [0:ITERS];
  logic signed [XW-1:0] c_x_q    [0:ITERS];
  logic signed [XW-1:0] c_y_q    [0:ITERS];
  logic signed [ZW-1:0] c_z_q    [0:ITERS];
  info_t                c_info_q [0:ITERS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q[0] <= 1'b0;
    end else if (en) begin
      c_vld_q[0] <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_x_q[0]    <= $signed({(XW - MAG_W - GUARD)'(0), p, GUARD'(0)});
      c_y_q[0]    <= $signed({(XW - MAG_W - GUARD)'(0), q, GUARD'(0)});
      c_z_q[0]    <= '0;
      c_info_q[0] <= fold_info;
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ATAN = $signed(atan_lut(i));
    logic signed [XW-1:0] dx, dy;

    assign dx = c_y_q[i] >>> i;
    assign dy = c_x_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        c_vld_q[i+1] <= 1'b0;
      end else if (en) begin
        c_vld_q[i+1] <= c_vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!c_y_q[i][XW-1]) begin
          c_x_q[i+1] <= c_x_q[i] + dx;
          c_y_q[i+1] <= c_y_q[i] - dy;
          c_z_q[i+1] <= c_z_q[i] + ATAN;
        end else begin
          c_x_q[i+1] <= c_x_q[i] - dx;
          c_y_q[i+1] <= c_y_q[i] + dy;
          c_z_q[i+1] <= c_z_q[i] - ATAN;
        end
        c_info_q[i+1] <= c_info_q[i];
      end
    end
  end

  // clamp and octant rebuild
  logic [TW-1:0] zc, t_d;

  always_comb begin
    if (c_z_q[ITERS][ZW-1]) begin
      zc = '0;
    end else if (c_z_q[ITERS] > $signed({1'b0, DEG45})) begin
      zc = DEG45;
    end else begin
      zc = c_z_q[ITERS][TW-1:0];
    end
    unique case (c_info_q[ITERS].kind)
      KIND_ZERO_DEG: t_d = '0;
      KIND_RIGHT:    t_d = DEG90;
      KIND_DIAG:     t_d = DEG45;
      KIND_OCT:      t_d = zc;
      KIND_OCT_SWAP: t_d = DEG90 - zc;
      default:       t_d = '0;
    endcase
  end

  logic          f1_vld_q;
  logic [TW-1:0] t_q;
  info_t         f1_info_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
    end else if (en) begin
      f1_vld_q <= c_vld_q[ITERS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q       <= t_d;
      f1_info_q <= c_info_q[ITERS];
    end
  end

  // quadrant rebuild
  logic [AW-1:0] t_ext, a_raw, a_d;

  always_comb begin
    t_ext = {(AW - TW)'(0), t_q};
    priority if (!f1_info_q.u_neg && !f1_info_q.v_neg) begin
      a_raw = t_ext;
    end else if (!f1_info_q.v_neg) begin
      a_raw = DEG180 - t_ext;
    end else if (f1_info_q.u_neg) begin
      a_raw = DEG180 + t_ext;
    end else begin
      a_raw = DEG360 - t_ext;
    end
    a_d = (a_raw >= DEG360) ? a_raw - DEG360 : a_raw;
  end

  logic          f2_vld_q;
  logic [AW-1:0] a_q;
  logic          f2_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_vld_q <= 1'b0;
    end else if (en) begin
      f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q       <= a_d;
      f2_zero_q <= f1_info_q.zero;
    end
  end

  // round to output precision
  logic [AW:0]                      a_sum;
  logic [AW-ROUND_SHIFT:0]          r_full;
  logic [ANGLE_WIDTH-1:0]           push_angle;
  logic                             push;

  always_comb begin
    a_sum  = {1'b0, a_q} + ROUND_HALF;
    r_full = a_sum[AW:ROUND_SHIFT];
    if (f2_zero_q || (r_full >= (AW - ROUND_SHIFT + 1)'(FULL_TURN))) begin
      push_angle = '0;
    end else begin
      push_angle = r_full[ANGLE_WIDTH-1:0];
    end
  end

  assign push = en && f2_vld_q;

  // two-entry output buffer
  logic [ANGLE_WIDTH-1:0] out_angle_q, skid_angle_q;
  logic                   out_zero_q, skid_zero_q;
  logic                   load_out, load_skid, from_skid;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    load_out   = 1'b0;
    load_skid  = 1'b0;
    from_skid  = 1'b0;
    if (skid_vld_q) begin
      if (ready_i) begin
        from_skid  = 1'b1;
        skid_vld_d = 1'b0;
      end
    end else if (push) begin
      if (!out_vld_q || ready_i) begin
        load_out  = 1'b1;
        out_vld_d = 1'b1;
      end else begin
        load_skid  = 1'b1;
        skid_vld_d = 1'b1;
      end
    end else if (ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (from_skid) begin
      out_angle_q <= skid_angle_q;
      out_zero_q  <= skid_zero_q;
    end else if (load_out) begin
      out_angle_q <= push_angle;
      out_zero_q  <= f2_zero_q;
    end
    if (load_skid) begin
      skid_angle_q <= push_angle;
      skid_zero_q  <= f2_zero_q;
    end
  end

  assign valid_o       = out_vld_q;
  assign angle_o       = out_angle_q;
  assign zero_vector_o = out_zero_q;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held without an output entry");

  a_zero_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && zero_vector_o) |-> (angle_o == '0))
    else $error("zero vector beat with nonzero angle");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (angle_o < FULL_TURN))
    else $error("angle at or beyond a full turn");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && ready_i) |=> (!skid_vld_q && out_vld_q))
    else $error("skid entry not moved to output");
`endif

endmodule

// ===== sim/vector_direction_angle_tb.sv =====
// vector_direction_angle_tb: self-checking testbench for the screen-space vector angle unit
// predicts each angle with its own folded cordic and checks every output beat in order
// depends on vda_pkg and vector_direction_angle
module vector_direction_angle_tb
  import vda_pkg::*;
();

  localparam int          CW          = COMPONENT_WIDTH;
  localparam int          RSHIFT      = 20 - ANGLE_FRACTION_BITS;
  localparam longint      DEG_ONE     = 1048576;
  localparam int          STEPS       = 24;
  localparam int          MAX_IDLE    = 13;
  localparam int          HOLD_LEN    = 300;
  localparam int          DRAIN_TAIL  = 40;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [CW-1:0]   vx;
    logic signed [CW-1:0]   vy;
    logic [ANGLE_WIDTH-1:0] angle;
    logic                   zero;
  } direction_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   valid_i = 1'b0;
  logic                   ready_o;
  logic signed [CW-1:0]   velocity_x_i = '0;
  logic signed [CW-1:0]   velocity_y_i = '0;
  logic                   valid_o;
  logic                   ready_i = 1'b0;
  logic [ANGLE_WIDTH-1:0] angle_o;
  logic                   zero_vector_o;

  // atan(2^-i) in 2^-20 degree
  longint atan_step [0:STEPS-1] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
    938658, 469357, 234682, 117342, 58671, 29335,
    14668, 7334, 3667, 1833, 917, 458,
    229, 115, 57, 29, 14, 7
  };

  direction_t  expected_angles[$];
  int unsigned vectors_sent;
  int unsigned angles_checked;
  int unsigned zero_vectors_seen;
  int unsigned angle_errors;
  int unsigned cycle_count;
  int unsigned longest_hold;
  int          hold_cycles;
  bit          source_busy;
  bit          sink_busy;

  vector_direction_angle u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .ready_o      (ready_o),
    .velocity_x_i (velocity_x_i),
    .velocity_y_i (velocity_y_i),
    .valid_o      (valid_o),
    .ready_i      (ready_i),
    .angle_o      (angle_o),
    .zero_vector_o(zero_vector_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d angles still pending",
               cycle_count, expected_angles.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // atan(q/p) in 2^-20 degree for 0 < q < p
  function automatic longint cordic_first_octant(input longint p, input longint q);
    longint cx, cy, cz, dx, dy;
    cx = p <<< 24;
    cy = q <<< 24;
    cz = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx = cx + dx;
        cy = cy - dy;
        cz = cz + atan_step[i];
      end else begin
        cx = cx - dx;
        cy = cy + dy;
        cz = cz - atan_step[i];
      end
    end
    if (cz < 0) cz = 0;
    if (cz > 45 * DEG_ONE) cz = 45 * DEG_ONE;
    return cz;
  endfunction

  function automatic direction_t predict_direction(input logic signed [CW-1:0] vx,
                                                   input logic signed [CW-1:0] vy);
    longint     u, v, au, av, t, a, r, full;
    direction_t res;
    res.vx = vx;
    res.vy = vy;
    u = vx;
    v = vy;
    v = -v;
    au = (u < 0) ? -u : u;
    av = (v < 0) ? -v : v;
    full = longint'(360) <<< ANGLE_FRACTION_BITS;
    if (u == 0 && v == 0) begin
      res.angle = '0;
      res.zero  = 1'b1;
      return res;
    end
    if (av == 0) t = 0;
    else if (au == 0) t = 90 * DEG_ONE;
    else if (au == av) t = 45 * DEG_ONE;
    else if (av < au) t = cordic_first_octant(au, av);
    else t = 90 * DEG_ONE - cordic_first_octant(av, au);
    if (u >= 0 && v >= 0) a = t;
    else if (u < 0 && v >= 0) a = 180 * DEG_ONE - t;
    else if (u < 0) a = 180 * DEG_ONE + t;
    else a = 360 * DEG_ONE - t;
    if (a >= 360 * DEG_ONE) a = a - 360 * DEG_ONE;
    r = (a + (longint'(1) <<< (RSHIFT - 1))) >>> RSHIFT;
    if (r >= full) r = 0;
    res.angle = ANGLE_WIDTH'(r);
    res.zero  = 1'b0;
    return res;
  endfunction

  // called at a rising edge, returns at the edge that takes the beat
  task automatic send_vector(input logic signed [CW-1:0] vx, input logic signed [CW-1:0] vy);
    int gap;
    gap = source_busy ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i      <= 1'b1;
    velocity_x_i <= vx;
    velocity_y_i <= vy;
    do @(negedge clk_i); while (!ready_o);
    expected_angles.push_back(predict_direction(vx, vy));
    @(posedge clk_i);
    vectors_sent++;
  endtask

  function automatic logic signed [CW-1:0] any_component();
    int pick;
    pick = $urandom_range(0, 15);
    case (pick)
      0: return {1'b1, {(CW-1){1'b0}}};
      1: return {1'b0, {(CW-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic shuffle_idling();
    source_busy = ($urandom_range(0, 3) != 0);
    sink_busy   = ($urandom_range(0, 3) != 0);
  endtask

  task automatic test_directed();
    logic signed [CW-1:0] lo, hi;
    lo = {1'b1, {(CW-1){1'b0}}};
    hi = {1'b0, {(CW-1){1'b1}}};
    source_busy = 1'b0;
    sink_busy   = 1'b0;
    send_vector(0, 0);
    send_vector(5, 0);
    send_vector(0, -5);
    send_vector(-5, 0);
    send_vector(0, 5);
    send_vector(7, -7);
    send_vector(-7, -7);
    send_vector(-7, 7);
    send_vector(7, 7);
    send_vector(lo, 0);
    send_vector(0, lo);
    send_vector(lo, lo);
    send_vector(hi, hi);
    send_vector(hi, lo);
    send_vector(lo, hi);
    send_vector(hi, 0);
    send_vector(0, hi);
    // just below the x axis, rounds up to a full turn
    send_vector(hi, 1);
    send_vector(hi, -1);
    send_vector(2, -1);
    send_vector(-1, 2);
    send_vector(1, -1);
    send_vector(-1, -1);
  endtask

  task automatic test_random_wide(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) shuffle_idling();
      send_vector(any_component(), any_component());
    end
  endtask

  task automatic test_random_small(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) shuffle_idling();
      if (n < 100) begin
        source_busy = 1'b0;
        sink_busy   = 1'b0;
      end
      send_vector(CW'($urandom_range(0, 16) - 8), CW'($urandom_range(0, 16) - 8));
    end
  endtask

  task automatic test_near_axes_diagonals(input int count);
    logic signed [CW-1:0] m, d;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) shuffle_idling();
      m = any_component();
      d = CW'($urandom_range(0, 6) - 3);
      case ($urandom_range(0, 3))
        0: send_vector(m, d);
        1: send_vector(d, m);
        2: send_vector(m, m + d);
        default: send_vector(m, -m + d);
      endcase
    end
  endtask

  task automatic test_backpressure(input int count);
    source_busy = 1'b0;
    sink_busy   = 1'b0;
    hold_cycles = HOLD_LEN;
    for (int n = 0; n < count; n++) send_vector(any_component(), any_component());
  endtask

  initial begin : receiver
    int stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
        if (stall > longest_hold) longest_hold = stall;
      end else begin
        stall = sink_busy ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (stall > 0) begin
        ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      ready_i <= 1'b1;
      do @(negedge clk_i); while (!valid_o);
      @(posedge clk_i);
    end
  end

  always @(negedge clk_i) begin : check_angle
    direction_t want;
    if (rst_ni && valid_o && ready_i) begin
      angles_checked++;
      if (expected_angles.size() == 0) begin
        angle_errors++;
        if (angle_errors <= 10)
          $display("unexpected beat: angle=%0d zero=%0b", angle_o, zero_vector_o);
      end else begin
        want = expected_angles.pop_front();
        if (want.zero) zero_vectors_seen++;
        if (angle_o !== want.angle || zero_vector_o !== want.zero) begin
          angle_errors++;
          if (angle_errors <= 10)
            $display("bad beat for x=%0d y=%0d: angle exp %0d got %0d, zero exp %0b got %0b",
                     want.vx, want.vy, want.angle, angle_o, want.zero, zero_vector_o);
        end
      end
    end
  end

  initial begin : stimulus
    vectors_sent      = 0;
    angles_checked    = 0;
    zero_vectors_seen = 0;
    angle_errors      = 0;
    cycle_count       = 0;
    longest_hold      = 0;
    hold_cycles       = 0;
    source_busy       = 1'b0;
    sink_busy         = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_wide(700);
    test_random_small(250);
    test_backpressure(90);
    test_near_axes_diagonals(330);

    valid_i <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);

    $display("%0d vectors sent, %0d angles checked, %0d of them zero vectors",
             vectors_sent, angles_checked, zero_vectors_seen);
    $display("covered axes, diagonals, extreme components, wrap at full turn, %0d-cycle sink hold",
             longest_hold);
    if (angle_errors == 0 && expected_angles.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", angle_errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/vda_pkg.sv
hdl/vector_direction_angle.sv
sim/vector_direction_angle_tb.sv
